@@ hdl/hrp_pkg.sv @@
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared types and constants for the hue rotation palette generator.
// ----------------------------------------------------------------------------
package hrp_pkg;

    localparam int HUE_FRACTION_BITS_DEF = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HUE_STEP      = 2'd1;

    localparam logic [3:0]  PALETTE_COUNT_RST = 4'd5;
    localparam logic [15:0] HUE_STEP_RST      = 16'd6554;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [2:0] entry_index;
        logic       last_entry;
    } pixel_out_t;

endpackage

@@ hdl/hue_rotation_palette_generator.sv @@
// ----------------------------------------------------------------------------
// hue_rotation_palette_generator
// RGB colour in, run of hue-rotated palette colours out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | pixel_in_t
//  out     | output    | out_valid/out_stall | pixel_out_t
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
//  One palette entry leaves per cycle unless out_stall holds it; an input
//  item gives palette_count entries (1 to 8), set by the entry generator
//  that steps the hue. The dividers have max(16, HUE_FRACTION_BITS) stages.
//  out_stall freezes the whole pipeline while out_valid is high; nothing is
//  dropped or repeated. Reset clears all valid bits, loads register defaults.
// ----------------------------------------------------------------------------
module hue_rotation_palette_generator #(
    parameter int HUE_FRACTION_BITS = hrp_pkg::HUE_FRACTION_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  hrp_pkg::pixel_in_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output hrp_pkg::pixel_out_t                out_data,
    input  logic                               cfg_we,
    input  logic [hrp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hrp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int F = HUE_FRACTION_BITS;

    logic [3:0]    count_reg;
    logic [15:0]   step_reg;
    logic [F+15:0] step_wide;
    logic [F-1:0]  step;

    logic          adv, front_adv;
    logic          fv, gv, gfree, glast;
    logic [7:0]    f_mx, g_mx;
    logic [15:0]   f_sat, g_sat;
    logic [F-1:0]  f_hue, g_hue;
    logic [2:0]    g_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= hrp_pkg::PALETTE_COUNT_RST;
            step_reg  <= hrp_pkg::HUE_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hrp_pkg::CFG_PALETTE_COUNT: count_reg <= cfg_data[3:0];
                hrp_pkg::CFG_HUE_STEP:      step_reg  <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // step in hue units: times 2^F / 2^16, truncated
    assign step_wide = {step_reg, {F{1'b0}}};
    assign step      = step_wide[F+15:16];

    assign adv       = !out_valid || !out_stall;
    assign front_adv = adv && (gfree || !fv);
    assign in_stall  = !front_adv;

    hrp_hsv_front #(.HUE_FRACTION_BITS(F)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (front_adv),
        .in_valid (in_valid),
        .in_data  (in_data),
        .out_valid(fv),
        .mx       (f_mx),
        .sat      (f_sat),
        .hue      (f_hue)
    );

    hrp_entry_gen #(.HUE_FRACTION_BITS(F)) u_gen (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (fv),
        .in_mx    (f_mx),
        .in_sat   (f_sat),
        .in_hue   (f_hue),
        .count_cfg(count_reg),
        .step     (step),
        .free     (gfree),
        .out_valid(gv),
        .mx       (g_mx),
        .sat      (g_sat),
        .hue      (g_hue),
        .idx      (g_idx),
        .last     (glast)
    );

    hrp_rgb_back #(.HUE_FRACTION_BITS(F)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (gv),
        .in_mx    (g_mx),
        .in_sat   (g_sat),
        .in_hue   (g_hue),
        .in_idx   (g_idx),
        .in_last  (glast),
        .out_valid(out_valid),
        .out_data (out_data)
    );

endmodule

@@ hdl/hrp_div_pipe.sv @@
// ----------------------------------------------------------------------------
// hrp_div_pipe
// Restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module hrp_div_pipe #(
    parameter int QW = 16,
    parameter int DW = 8,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] rem0,     // top of numerator, below divisor
    input  logic [QW-1:0] low,      // remaining numerator bits
    input  logic [DW-1:0] divisor,
    input  logic [PW-1:0] side,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [PW-1:0] side_out
);

    logic          valid_reg [QW];
    logic [DW-1:0] rem_reg   [QW];
    logic [QW-1:0] low_reg   [QW];
    logic [QW-1:0] quo_reg   [QW];
    logic [DW-1:0] div_reg   [QW];
    logic [PW-1:0] side_reg  [QW];

    // stage inputs: the ports for stage 0, the previous stage otherwise
    logic          v_prev   [QW];
    logic [DW-1:0] r_prev   [QW];
    logic [QW-1:0] l_prev   [QW];
    logic [QW-1:0] q_prev   [QW];
    logic [DW-1:0] d_prev   [QW];
    logic [PW-1:0] s_prev   [QW];
    logic [DW:0]   trial    [QW];
    logic          fits     [QW];
    logic [DW-1:0] rem_next [QW];

    always_comb
    begin
        v_prev[0] = in_valid;
        r_prev[0] = rem0;
        l_prev[0] = low;
        q_prev[0] = '0;
        d_prev[0] = divisor;
        s_prev[0] = side;
        for (int k = 1; k < QW; k++)
        begin
            v_prev[k] = valid_reg[k-1];
            r_prev[k] = rem_reg[k-1];
            l_prev[k] = low_reg[k-1];
            q_prev[k] = quo_reg[k-1];
            d_prev[k] = div_reg[k-1];
            s_prev[k] = side_reg[k-1];
        end
        for (int k = 0; k < QW; k++)
        begin
            trial[k]    = {r_prev[k], l_prev[k][QW-1]};
            fits[k]     = (trial[k] >= {1'b0, d_prev[k]});
            rem_next[k] = fits[k] ? DW'(trial[k] - {1'b0, d_prev[k]}) : trial[k][DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                valid_reg[k] <= v_prev[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                low_reg[k]  <= {l_prev[k][QW-2:0], 1'b0};
                quo_reg[k]  <= {q_prev[k][QW-2:0], fits[k]};
                div_reg[k]  <= d_prev[k];
                side_reg[k] <= s_prev[k];
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

@@ hdl/hrp_hsv_front.sv @@
// ----------------------------------------------------------------------------
// hrp_hsv_front
// RGB to HSV: max/min, hue numerator, then pipelined saturation and hue
// divisions.
// ----------------------------------------------------------------------------
module hrp_hsv_front #(
    parameter int HUE_FRACTION_BITS = hrp_pkg::HUE_FRACTION_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  hrp_pkg::pixel_in_t           in_data,
    output logic                         out_valid,
    output logic [7:0]                   mx,
    output logic [15:0]                  sat,
    output logic [HUE_FRACTION_BITS-1:0] hue
);

    localparam int F = HUE_FRACTION_BITS;
    localparam int L = (F > 16) ? F : 16;

    logic [7:0]   r, g, b, mx_c, mn_c, d;
    logic [10:0]  n;
    logic [23:0]  snum;
    logic [L+7:0] snum_w;
    logic         v_s, v_h;
    logic [L-1:0] q_s, q_h;
    logic [7:0]   mx_s;
    logic         dnz_h;

    always_comb
    begin
        r    = in_data.red_in;
        g    = in_data.green_in;
        b    = in_data.blue_in;
        mx_c = r;
        if (g > mx_c) mx_c = g;
        if (b > mx_c) mx_c = b;
        mn_c = r;
        if (g < mn_c) mn_c = g;
        if (b < mn_c) mn_c = b;
        d = mx_c - mn_c;
        // red wins ties, then green
        if (mx_c == r)
        begin
            if (g >= b) n = 11'(g) - 11'(b);
            else        n = 11'(6) * 11'(d) - (11'(b) - 11'(g));
        end
        else if (mx_c == g)
        begin
            n = 11'(2) * 11'(d) + 11'(b) - 11'(r);
        end
        else
        begin
            n = 11'(4) * 11'(d) + 11'(r) - 11'(g);
        end
        snum   = {d, 16'd0} - 24'(d);
        snum_w = (L+8)'(snum) << (L-16);
    end

    hrp_div_pipe #(.QW(L), .DW(8), .PW(8)) u_sat_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .rem0     (snum_w[L+7:L]),
        .low      (snum_w[L-1:0]),
        .divisor  (mx_c),
        .side     (mx_c),
        .out_valid(v_s),
        .quo      (q_s),
        .side_out (mx_s)
    );

    hrp_div_pipe #(.QW(L), .DW(11), .PW(1)) u_hue_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .rem0     (n),
        .low      ('0),
        .divisor  (11'(6) * 11'(d)),
        .side     (d != 8'd0),
        .out_valid(v_h),
        .quo      (q_h),
        .side_out (dnz_h)
    );

    assign out_valid = v_s & v_h;
    assign mx        = mx_s;
    assign sat       = (mx_s == 8'd0) ? 16'd0 : q_s[L-1:L-16];
    assign hue       = dnz_h ? q_h[L-1:L-F] : '0;

endmodule

@@ hdl/hrp_entry_gen.sv @@
// ----------------------------------------------------------------------------
// hrp_entry_gen
// Holds one HSV colour and steps the hue once per palette entry.
// ----------------------------------------------------------------------------
module hrp_entry_gen #(
    parameter int HUE_FRACTION_BITS = hrp_pkg::HUE_FRACTION_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [7:0]                   in_mx,
    input  logic [15:0]                  in_sat,
    input  logic [HUE_FRACTION_BITS-1:0] in_hue,
    input  logic [3:0]                   count_cfg,
    input  logic [HUE_FRACTION_BITS-1:0] step,
    output logic                         free,
    output logic                         out_valid,
    output logic [7:0]                   mx,
    output logic [15:0]                  sat,
    output logic [HUE_FRACTION_BITS-1:0] hue,
    output logic [2:0]                   idx,
    output logic                         last
);

    logic                         valid_reg;
    logic [7:0]                   mx_reg;
    logic [15:0]                  sat_reg;
    logic [HUE_FRACTION_BITS-1:0] hue_reg;
    logic [2:0]                   idx_reg;
    logic [3:0]                   count_reg;
    logic [3:0]                   count_next;

    always_comb
    begin
        if (count_cfg == 4'd0)     count_next = 4'd1;
        else if (count_cfg > 4'd8) count_next = 4'd8;
        else                       count_next = count_cfg;
    end

    assign last = ({1'b0, idx_reg} + 4'd1) == count_reg;
    assign free = !valid_reg || last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en && free)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (free)
            begin
                mx_reg    <= in_mx;
                sat_reg   <= in_sat;
                hue_reg   <= in_hue;
                idx_reg   <= 3'd0;
                count_reg <= count_next;
            end
            else
            begin
                hue_reg <= hue_reg + step;
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    assign out_valid = valid_reg;
    assign mx        = mx_reg;
    assign sat       = sat_reg;
    assign hue       = hue_reg;
    assign idx       = idx_reg;

endmodule

@@ hdl/hrp_rgb_back.sv @@
// ----------------------------------------------------------------------------
// hrp_rgb_back
// HSV to RGB, six-sector rule, four register stages ending in the output
// register.
// ----------------------------------------------------------------------------
module hrp_rgb_back #(
    parameter int HUE_FRACTION_BITS = hrp_pkg::HUE_FRACTION_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [7:0]                   in_mx,
    input  logic [15:0]                  in_sat,
    input  logic [HUE_FRACTION_BITS-1:0] in_hue,
    input  logic [2:0]                   in_idx,
    input  logic                         in_last,
    output logic                         out_valid,
    output hrp_pkg::pixel_out_t          out_data
);

    localparam int F = HUE_FRACTION_BITS;
    localparam logic [F+15:0] FULL = {16'hFFFF, {F{1'b0}}};   // one turn * 65535

    // stage 1: sector and fraction
    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic [7:0]    mx1_reg, mx2_reg, mx3_reg;
    logic [15:0]   s1_reg;
    logic [2:0]    sec1_reg, sec2_reg, sec3_reg;
    logic [F-1:0]  f1_reg;
    logic [2:0]    i1_reg, i2_reg, i3_reg;
    logic          l1_reg, l2_reg, l3_reg;
    logic [F+2:0]  six;

    // stage 2: k * s
    logic [F+15:0] pp2_reg, pq2_reg, pt2_reg;
    logic [F:0]    omf;

    // stage 3: v * (1 - k*s)
    logic [F+23:0] mp3_reg, mq3_reg, mt3_reg;

    hrp_pkg::pixel_out_t out_reg, out_next;

    assign six = ({3'b0, in_hue} << 2) + ({3'b0, in_hue} << 1);
    assign omf = {1'b1, {F{1'b0}}} - {1'b0, f1_reg};

    function automatic logic [7:0] to_chan(input logic [F+23:0] m);
        logic [23:0] y;
        logic [24:0] t;
        begin
            y = m[F+23:F];
            // floor(y / 65535) for y below 256 * 65535
            t = 25'(y) + 25'(y[23:16]) + 25'd1;
            to_chan = t[23:16];
        end
    endfunction

    always_comb
    begin
        logic [7:0] cv, cp, cq, ct;
        cv = mx3_reg;
        cp = to_chan(mp3_reg);
        cq = to_chan(mq3_reg);
        ct = to_chan(mt3_reg);
        out_next.entry_index = i3_reg;
        out_next.last_entry  = l3_reg;
        case (sec3_reg)
            3'd0:
            begin
                out_next.red_out = cv; out_next.green_out = ct; out_next.blue_out = cp;
            end
            3'd1:
            begin
                out_next.red_out = cq; out_next.green_out = cv; out_next.blue_out = cp;
            end
            3'd2:
            begin
                out_next.red_out = cp; out_next.green_out = cv; out_next.blue_out = ct;
            end
            3'd3:
            begin
                out_next.red_out = cp; out_next.green_out = cq; out_next.blue_out = cv;
            end
            3'd4:
            begin
                out_next.red_out = ct; out_next.green_out = cp; out_next.blue_out = cv;
            end
            default:
            begin
                out_next.red_out = cv; out_next.green_out = cp; out_next.blue_out = cq;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx1_reg  <= in_mx;
            s1_reg   <= in_sat;
            sec1_reg <= six[F+2:F];
            f1_reg   <= six[F-1:0];
            i1_reg   <= in_idx;
            l1_reg   <= in_last;

            mx2_reg  <= mx1_reg;
            sec2_reg <= sec1_reg;
            i2_reg   <= i1_reg;
            l2_reg   <= l1_reg;
            pp2_reg  <= {s1_reg, {F{1'b0}}};
            pq2_reg  <= (F+16)'(f1_reg) * (F+16)'(s1_reg);
            pt2_reg  <= (F+16)'(omf) * (F+16)'(s1_reg);

            mx3_reg  <= mx2_reg;
            sec3_reg <= sec2_reg;
            i3_reg   <= i2_reg;
            l3_reg   <= l2_reg;
            mp3_reg  <= (F+24)'(mx2_reg) * (F+24)'(FULL - pp2_reg);
            mq3_reg  <= (F+24)'(mx2_reg) * (F+24)'(FULL - pq2_reg);
            mt3_reg  <= (F+24)'(mx2_reg) * (F+24)'(FULL - pt2_reg);

            out_reg  <= out_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = out_reg;

endmodule
